>>> rtl/core/swtq_pkg.sv
// ============================================================================
// Sorted wakeup timer queue package
// Shared operation codes, controller states and the command and status
// structs that join the controller to the datapath.
// ============================================================================
package swtq_pkg;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_GAP,
    RD_JDX_M1,
    RD_ZERO
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SHL,
    WR_SHR,
    WR_NEW
  } wr_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_FIND_CMP,
    ST_SHL_CHK,
    ST_SHL_WR,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_SHR_CHK,
    ST_SHR_WR,
    ST_CHK_CHK,
    ST_CHK_CMP,
    ST_EMT_RD,
    ST_EMT_WAIT,
    ST_STS_RD,
    ST_STS_CAP,
    ST_STS_WAIT
  } state_e;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    idx_clr;
    logic    idx_inc;
    logic    jdx_load;
    logic    jdx_dec;
    logic    gap_one;
    logic    gap_idx;
    logic    cnt_sub;
    logic    cnt_inc;
    logic    q_set_task;
    logic    q_clr_task;
    logic    q_clr_rd;
    logic    st_ones;
    logic    st_rd;
    logic    out_load;
    logic    out_woken;
  } cmd_t;

  typedef struct packed {
    logic is_set;
    logic is_remove;
    logic is_check;
    logic task_ok;
    logic task_queued;
    logic cnt_zero;
    logic cnt_full;
    logic idx_lt_cnt;
    logic idx_gap_lt_cnt;
    logic jdx_gt_idx;
    logic idx_zero;
    logic rd_match;
    logic rd_le_wake;
    logic rd_le_now;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/swtq_datapath.sv
// ============================================================================
// Sorted wakeup timer queue datapath
// Holds the ordered entry memory, per-task queued bits, the list counters,
// the status registers and the output register.
// ============================================================================
module swtq_datapath #(
  parameter int unsigned NUM_TASKS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        in_kind_i,
  input  logic [4:0]        in_task_i,
  input  logic [63:0]       in_wake_i,
  input  logic [63:0]       in_now_i,
  input  swtq_pkg::cmd_t    cmd_i,
  output swtq_pkg::sts_t    sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_woken_valid_o,
  output logic [4:0]        out_woken_task_o,
  output logic              out_last_o,
  output logic [63:0]       out_next_wake_o,
  output logic              out_pending_o
);
  import swtq_pkg::*;

  localparam int unsigned AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CW = $clog2(NUM_TASKS + 1);

  typedef struct packed {
    logic [63:0]   wake;
    logic [AW-1:0] id;
  } entry_t;

  entry_t               list_mem [NUM_TASKS];
  entry_t               rd_q;
  entry_t               wr_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  logic [1:0]           kind_q;
  logic [4:0]           task_q;
  logic [63:0]          wake_q;
  logic [63:0]          now_q;

  logic [NUM_TASKS-1:0] queued_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        idx_q;
  logic [CW-1:0]        jdx_q;
  logic [CW-1:0]        gap_q;
  logic [63:0]          st_next_q;
  logic                 st_pend_q;

  logic                 out_valid_q;
  logic                 out_woken_q;
  logic [4:0]           out_task_q;
  logic                 out_last_q;
  logic [63:0]          out_next_q;
  logic                 out_pend_q;

  logic [6:0]           task_ext;
  logic [AW-1:0]        task_id;
  logic [6:0]           rd_id_ext;
  logic [CW:0]          idx_gap;
  logic [CW:0]          idx_p1;
  logic [CW-1:0]        jdx_m1;

  assign task_ext  = {2'b00, task_q};
  assign task_id   = task_ext[AW-1:0];
  assign rd_id_ext = 7'(rd_q.id);
  assign idx_gap   = {1'b0, idx_q} + {1'b0, gap_q};
  assign idx_p1    = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
  assign jdx_m1    = jdx_q - {{(CW-1){1'b0}}, 1'b1};

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:     rd_addr = idx_q[AW-1:0];
      RD_IDX_GAP: rd_addr = idx_gap[AW-1:0];
      RD_JDX_M1:  rd_addr = jdx_m1[AW-1:0];
      RD_ZERO:    rd_addr = '0;
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_SHL: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = rd_q;
      end
      WR_SHR: begin
        wr_addr = jdx_q[AW-1:0];
        wr_data = rd_q;
      end
      WR_NEW: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = '{wake: wake_q, id: task_id};
      end
      default: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      list_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= list_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= in_kind_i;
      task_q <= in_task_i;
      wake_q <= in_wake_i;
      now_q  <= in_now_i;
    end
    if (cmd_i.st_ones) begin
      st_next_q <= '1;
      st_pend_q <= 1'b0;
    end else if (cmd_i.st_rd) begin
      st_next_q <= rd_q.wake;
      st_pend_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_woken_q <= cmd_i.out_woken;
      out_task_q  <= cmd_i.out_woken ? rd_id_ext[4:0] : 5'd0;
      out_last_q  <= cmd_i.out_woken ? sts_o.emit_last : 1'b1;
      out_next_q  <= st_next_q;
      out_pend_q  <= st_pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q    <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      jdx_q       <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.q_set_task) begin
        queued_q[task_id] <= 1'b1;
      end
      if (cmd_i.q_clr_task) begin
        queued_q[task_id] <= 1'b0;
      end
      if (cmd_i.q_clr_rd) begin
        queued_q[rd_q.id] <= 1'b0;
      end
      if (cmd_i.cnt_sub) begin
        count_q <= count_q - gap_q;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_p1[CW-1:0];
      end
      if (cmd_i.jdx_load) begin
        jdx_q <= count_q;
      end else if (cmd_i.jdx_dec) begin
        jdx_q <= jdx_m1;
      end
      if (cmd_i.gap_one) begin
        gap_q <= {{(CW-1){1'b0}}, 1'b1};
      end else if (cmd_i.gap_idx) begin
        gap_q <= idx_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.is_set         = (kind_q == KIND_SET);
    sts_o.is_remove      = (kind_q == KIND_REMOVE);
    sts_o.is_check       = (kind_q == KIND_CHECK);
    sts_o.task_ok        = (task_ext < 7'(NUM_TASKS));
    sts_o.task_queued    = sts_o.task_ok && queued_q[task_id];
    sts_o.cnt_zero       = (count_q == '0);
    sts_o.cnt_full       = (count_q == CW'(NUM_TASKS));
    sts_o.idx_lt_cnt     = (idx_q < count_q);
    sts_o.idx_gap_lt_cnt = (idx_gap < {1'b0, count_q});
    sts_o.jdx_gt_idx     = (jdx_q > idx_q);
    sts_o.idx_zero       = (idx_q == '0);
    sts_o.rd_match       = (rd_q.id == task_id);
    sts_o.rd_le_wake     = (rd_q.wake <= wake_q);
    sts_o.rd_le_now      = (rd_q.wake <= now_q);
    sts_o.emit_last      = (idx_p1 == {1'b0, gap_q});
    sts_o.out_free       = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign out_woken_valid_o = out_woken_q;
  assign out_woken_task_o  = out_task_q;
  assign out_last_o        = out_last_q;
  assign out_next_wake_o   = out_next_q;
  assign out_pending_o     = out_pend_q;

endmodule

>>> rtl/core/swtq_ctrl.sv
// ============================================================================
// Sorted wakeup timer queue controller
// Sequences list search, shift, insert, wake and status steps over the
// datapath through command and status structs.
// ============================================================================
module swtq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swtq_pkg::sts_t sts_i,
  output swtq_pkg::cmd_t cmd_o
);
  import swtq_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (sts_i.is_check) begin
          state_d = ST_CHK_CHK;
        end else if ((sts_i.is_set || sts_i.is_remove) && sts_i.task_queued) begin
          state_d = ST_FIND;
        end else if (sts_i.is_set && sts_i.task_ok && !sts_i.cnt_full) begin
          state_d = ST_INS_CHK;
        end else begin
          state_d = ST_STS_RD;
        end
      end
      ST_FIND:     state_d = ST_FIND_CMP;
      ST_FIND_CMP: state_d = sts_i.rd_match ? ST_SHL_CHK : ST_FIND;
      ST_SHL_CHK: begin
        priority if (sts_i.idx_gap_lt_cnt) state_d = ST_SHL_WR;
        else if (sts_i.is_check)           state_d = ST_IDLE;
        else if (sts_i.is_set)             state_d = ST_INS_CHK;
        else                               state_d = ST_STS_RD;
      end
      ST_SHL_WR:   state_d = ST_SHL_CHK;
      ST_INS_CHK:  state_d = sts_i.idx_lt_cnt ? ST_INS_CMP : ST_SHR_CHK;
      ST_INS_CMP:  state_d = sts_i.rd_le_wake ? ST_INS_CHK : ST_SHR_CHK;
      ST_SHR_CHK:  state_d = sts_i.jdx_gt_idx ? ST_SHR_WR : ST_STS_RD;
      ST_SHR_WR:   state_d = ST_SHR_CHK;
      ST_CHK_CHK: begin
        priority if (sts_i.idx_lt_cnt) state_d = ST_CHK_CMP;
        else if (sts_i.idx_zero)       state_d = ST_STS_WAIT;
        else                           state_d = ST_EMT_RD;
      end
      ST_CHK_CMP: begin
        priority if (sts_i.rd_le_now) state_d = ST_CHK_CHK;
        else if (sts_i.idx_zero)      state_d = ST_STS_WAIT;
        else                          state_d = ST_EMT_RD;
      end
      ST_EMT_RD:   state_d = ST_EMT_WAIT;
      ST_EMT_WAIT: begin
        if (sts_i.out_free) state_d = sts_i.emit_last ? ST_SHL_CHK : ST_EMT_RD;
      end
      ST_STS_RD:   state_d = sts_i.cnt_zero ? ST_STS_WAIT : ST_STS_CAP;
      ST_STS_CAP:  state_d = ST_STS_WAIT;
      ST_STS_WAIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.idx_clr = 1'b1;
        cmd_o.gap_one = 1'b1;
      end
      ST_FIND: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX;
      end
      ST_FIND_CMP: begin
        cmd_o.idx_inc = !sts_i.rd_match;
      end
      ST_SHL_CHK: begin
        if (sts_i.idx_gap_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_GAP;
        end else begin
          cmd_o.cnt_sub    = 1'b1;
          cmd_o.q_clr_task = !sts_i.is_check;
          cmd_o.idx_clr    = 1'b1;
        end
      end
      ST_SHL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_SHL;
        cmd_o.idx_inc = 1'b1;
      end
      ST_INS_CHK: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
        end else begin
          cmd_o.jdx_load = 1'b1;
        end
      end
      ST_INS_CMP: begin
        cmd_o.idx_inc  = sts_i.rd_le_wake;
        cmd_o.jdx_load = !sts_i.rd_le_wake;
      end
      ST_SHR_CHK: begin
        if (sts_i.jdx_gt_idx) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_JDX_M1;
        end else begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = WR_NEW;
          cmd_o.q_set_task = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
        end
      end
      ST_SHR_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_SHR;
        cmd_o.jdx_dec = 1'b1;
      end
      ST_CHK_CHK: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
        end else begin
          cmd_o.st_ones = 1'b1;
          cmd_o.gap_idx = 1'b1;
          cmd_o.idx_clr = 1'b1;
        end
      end
      ST_CHK_CMP: begin
        if (sts_i.rd_le_now) begin
          cmd_o.idx_inc = 1'b1;
        end else begin
          cmd_o.st_rd   = 1'b1;
          cmd_o.gap_idx = 1'b1;
          cmd_o.idx_clr = 1'b1;
        end
      end
      ST_EMT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX;
      end
      ST_EMT_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_woken = 1'b1;
          cmd_o.q_clr_rd  = 1'b1;
          cmd_o.idx_clr   = sts_i.emit_last;
          cmd_o.idx_inc   = !sts_i.emit_last;
        end
      end
      ST_STS_RD: begin
        if (sts_i.cnt_zero) begin
          cmd_o.st_ones = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ZERO;
        end
      end
      ST_STS_CAP: begin
        cmd_o.st_rd = 1'b1;
      end
      ST_STS_WAIT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/sorted_wakeup_timer_queue_core.sv
// ============================================================================
// Sorted wakeup timer queue core
// Keeps queued tasks ordered by absolute wake time and reports due tasks.
// ============================================================================
// The slave channel takes one operation per beat: tuser carries the kind
// (set, remove, check), tdata the task slot, the wake time and the current
// time. The master channel returns result beats: a set, a remove or a check
// with nothing due gives one status beat; a check gives one beat per woken
// task, earliest first, with tlast on the final one. Every beat carries the
// earliest remaining wake time (all ones when empty) and the pending flag.
// One operation is handled at a time; the list lives in a memory with one
// read port and one write port, and every visited entry takes a read step
// followed by a compare or move step.
// A set or remove frees the slave side as soon as its status beat is loaded
// into the output register, so a new operation may enter while that beat
// still waits; a check first closes the gap left by the woken tasks.
// When the receiver stalls, the core holds the beat and waits before loading
// the next one. Reset empties the queue; no clearing pass is needed.
// ============================================================================
module sorted_wakeup_timer_queue_core #(
  parameter int unsigned NUM_TASKS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // task_req[4:0], wake_time[68:5], now_time[132:69]
  input  logic [1:0]   s_axis_tuser,  // kind[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // woken_task[4:0], next_wake[68:5], pending[69]
  output logic [0:0]   m_axis_tuser,  // woken_valid[0]
  output logic         m_axis_tlast
);
  import swtq_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        woken_valid;
  logic [4:0]  woken_task;
  logic [63:0] next_wake;
  logic        pending;

  swtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swtq_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_kind_i         (s_axis_tuser),
    .in_task_i         (s_axis_tdata[4:0]),
    .in_wake_i         (s_axis_tdata[68:5]),
    .in_now_i          (s_axis_tdata[132:69]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_woken_valid_o (woken_valid),
    .out_woken_task_o  (woken_task),
    .out_last_o        (m_axis_tlast),
    .out_next_wake_o   (next_wake),
    .out_pending_o     (pending)
  );

  assign m_axis_tdata = {2'b00, pending, next_wake, woken_task};
  assign m_axis_tuser = woken_valid;

  a_status_beat_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("status beat without tlast");

  a_empty_means_all_ones : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[69] |-> (&m_axis_tdata[68:5]))
    else $error("empty queue reported with a finite wake time");

  a_no_load_into_held_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a beat not yet taken");

  a_accept_starts_decode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("core ready again before decoding an operation");

endmodule

>>> dv/swtq_wake_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Sorted wakeup timer queue checker
// Watches both stream channels of the core. Every accepted operation beat is
// applied to a local copy of the ordered task list, and the beats it should
// produce are queued. Each result beat is compared field by field with the
// oldest queued beat.
// ============================================================================
module swtq_wake_checker #(
  parameter int unsigned NUM_TASKS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // task_req[4:0], wake_time[68:5], now_time[132:69]
  input  logic [1:0]   s_axis_tuser,  // kind[1:0]
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,  // woken_task[4:0], next_wake[68:5], pending[69]
  input  logic [0:0]   m_axis_tuser,  // woken_valid[0]
  input  logic         m_axis_tlast,
  output int unsigned  backlog_o,
  output int unsigned  errors_o,
  output int unsigned  woken_o
);
  import swtq_pkg::*;

  typedef struct packed {
    logic        woken_valid;
    logic [4:0]  woken_task;
    logic        last;
    logic [63:0] next_wake;
    logic        pending;
  } wake_report_t;

  logic [63:0]  wake_at [NUM_TASKS];
  bit           queued [NUM_TASKS];
  logic [4:0]   wake_order [$];
  wake_report_t report_q [$];

  int unsigned backlog = 0;
  int unsigned fault_count = 0;
  int unsigned woken_count = 0;

  assign backlog_o = backlog;
  assign errors_o  = fault_count;
  assign woken_o   = woken_count;

  function automatic void unlink_task(logic [4:0] slot);
    int unsigned pos;
    if (!queued[slot]) return;
    pos = 0;
    while (wake_order[pos] != slot) pos++;
    wake_order.delete(pos);
    queued[slot] = 1'b0;
  endfunction

  function automatic void predict_queue_op(kind_e op, logic [4:0] slot, logic [63:0] wake,
                                           logic [63:0] now);
    logic [4:0]  woke [$];
    int unsigned pos;
    logic        any_left;
    logic [63:0] head_time;
    case (op)
      KIND_SET: begin
        unlink_task(slot);
        pos = 0;
        while (pos < wake_order.size() && wake_at[wake_order[pos]] <= wake) pos++;
        wake_order.insert(pos, slot);
        wake_at[slot] = wake;
        queued[slot]  = 1'b1;
      end
      KIND_REMOVE: begin
        unlink_task(slot);
      end
      KIND_CHECK: begin
        while (wake_order.size() != 0 && wake_at[wake_order[0]] <= now) begin
          queued[wake_order[0]] = 1'b0;
          woke.push_back(wake_order.pop_front());
        end
      end
      default: begin
      end
    endcase
    any_left  = (wake_order.size() != 0);
    head_time = any_left ? wake_at[wake_order[0]] : '1;
    if (woke.size() == 0) begin
      report_q.push_back('{1'b0, 5'd0, 1'b1, head_time, any_left});
    end else begin
      foreach (woke[i]) begin
        report_q.push_back('{1'b1, woke[i], (i == woke.size() - 1), head_time, any_left});
      end
    end
  endfunction

  always @(posedge clk_i) begin : watch
    wake_report_t got;
    wake_report_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser[0], m_axis_tdata[4:0], m_axis_tlast, m_axis_tdata[68:5],
                m_axis_tdata[69]};
        if (report_q.size() == 0) begin
          fault_count++;
          $error("Result beat arrived with no expectation waiting.");
        end else begin
          want = report_q.pop_front();
          if (want.woken_valid) woken_count++;
          if (got.woken_valid !== want.woken_valid) begin
            fault_count++;
            $error("woken_valid: expected %0d, actual %0d", want.woken_valid, got.woken_valid);
          end
          if (got.woken_task !== want.woken_task) begin
            fault_count++;
            $error("woken_task: expected %0d, actual %0d", want.woken_task, got.woken_task);
          end
          if (got.last !== want.last) begin
            fault_count++;
            $error("last: expected %0d, actual %0d", want.last, got.last);
          end
          if (got.next_wake !== want.next_wake) begin
            fault_count++;
            $error("next_wake: expected %h, actual %h", want.next_wake, got.next_wake);
          end
          if (got.pending !== want.pending) begin
            fault_count++;
            $error("pending: expected %0d, actual %0d", want.pending, got.pending);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_queue_op(kind_e'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[68:5],
                         s_axis_tdata[132:69]);
      end
      backlog = report_q.size();
    end
  end

endmodule

>>> dv/tb_sorted_wakeup_timer_queue_core.sv
`timescale 1ns / 100ps
// ============================================================================
// Sorted wakeup timer queue core testbench
// Drives set, remove and check operations into the core: a directed opening
// on ties, extreme times and removal of absent tasks, then random bursts of
// sets around a shared time base followed by checks, and full-queue fills.
// Both channels stall at random; the checker predicts and compares beats.
// ============================================================================
module tb_sorted_wakeup_timer_queue_core;
  import swtq_pkg::*;

  localparam int unsigned NUM_TASKS    = 32;
  localparam int unsigned TARGET_OPS   = 320;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = KIND_CHECK;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int unsigned backlog;
  int unsigned mismatches;
  int unsigned tasks_woken;
  int unsigned ops_sent   = 0;
  int unsigned set_ops    = 0;
  int unsigned remove_ops = 0;
  int unsigned check_ops  = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on = 1'b1;

  sorted_wakeup_timer_queue_core #(
    .NUM_TASKS(NUM_TASKS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  swtq_wake_checker #(
    .NUM_TASKS(NUM_TASKS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .backlog_o    (backlog),
    .errors_o     (mismatches),
    .woken_o      (tasks_woken)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99) >= 13) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a beat.", STALL_LIMIT);
        $display("** sorted_wakeup_timer_queue_core: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] any_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_time(logic [63:0] base);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return any_word();
      default: return base + 64'($urandom_range(0, 24));
    endcase
  endfunction

  task automatic send_op(input kind_e op, input logic [4:0] slot, input logic [63:0] wake,
                         input logic [63:0] now);
    while (gaps_on && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, now, wake, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent++;
    case (op)
      KIND_SET:    set_ops++;
      KIND_REMOVE: remove_ops++;
      default:     check_ops++;
    endcase
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
  endtask

  task automatic fill_queue(input logic [63:0] base);
    logic [4:0]  slots [NUM_TASKS];
    logic [4:0]  swap;
    int unsigned j;
    foreach (slots[i]) slots[i] = 5'(i);
    for (int i = NUM_TASKS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      swap     = slots[i];
      slots[i] = slots[j];
      slots[j] = swap;
    end
    foreach (slots[i]) send_op(KIND_SET, slots[i], pick_time(base), any_word());
    send_op(KIND_CHECK, 5'($urandom_range(31)), any_word(), '1);
  endtask

  task automatic run_burst();
    logic [63:0] base;
    case ($urandom_range(3))
      0:       base = '0;
      1:       base = 64'hFFFF_FFFF_FFFF_FFC0;
      default: base = any_word();
    endcase
    repeat ($urandom_range(1, 12)) begin
      send_op(KIND_SET, 5'($urandom_range(31)), pick_time(base), any_word());
    end
    repeat ($urandom_range(0, 3)) begin
      send_op(KIND_REMOVE, 5'($urandom_range(31)), any_word(), any_word());
    end
    if ($urandom_range(5) == 0) wait_all_results();
    repeat ($urandom_range(1, 2)) begin
      send_op(KIND_CHECK, 5'($urandom_range(31)), any_word(), pick_time(base));
    end
  endtask

  initial begin
    int unsigned fills;
    fills = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(KIND_CHECK,  5'd0,  '0, '0);
    send_op(KIND_REMOVE, 5'd3,  '0, '0);
    send_op(KIND_SET,    5'd0,  '0, '1);
    send_op(KIND_SET,    5'd31, '1, '0);
    send_op(KIND_SET,    5'd5,  64'd100, '0);
    send_op(KIND_SET,    5'd6,  64'd100, '0);
    send_op(KIND_SET,    5'd7,  64'd100, '0);
    send_op(KIND_SET,    5'd5,  64'd100, '0);
    send_op(KIND_REMOVE, 5'd9,  '0, '0);
    send_op(KIND_REMOVE, 5'd6,  '0, '0);
    send_op(KIND_CHECK,  5'd0,  '0, '0);
    send_op(KIND_CHECK,  5'd0,  '0, 64'd99);
    send_op(KIND_SET,    5'd12, 64'h8000_0000_0000_0000, '0);
    send_op(KIND_SET,    5'd13, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_op(KIND_CHECK,  5'd31, '1, 64'd100);
    wait_all_results();
    send_op(KIND_CHECK,  5'd0,  '0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_op(KIND_CHECK,  5'd0,  '0, '1);
    send_op(KIND_SET,    5'd20, '1, '0);
    send_op(KIND_SET,    5'd21, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(KIND_SET,    5'd22, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_op(KIND_CHECK,  5'd10, '0, 64'h5555_5555_5555_5555);
    send_op(KIND_REMOVE, 5'd22, '0, '0);
    send_op(KIND_CHECK,  5'd0,  '0, '1);

    while (ops_sent < TARGET_OPS) begin
      gaps_on = !(ops_sent >= 120 && ops_sent < 200);
      if (fills < 2 && ops_sent >= 100 + 120 * fills) begin
        fill_queue(($urandom_range(1) == 0) ? '0 : any_word());
        fills++;
      end else if ($urandom_range(3) == 0) begin
        send_op(kind_e'($urandom_range(2)), 5'($urandom_range(31)), any_word(), any_word());
      end else begin
        run_burst();
      end
    end

    gaps_on = 1'b1;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d operations (%0d set, %0d remove, %0d check), including two full fills.",
             ops_sent, set_ops, remove_ops, check_ops);
    $display("Checks woke %0d tasks in total; both channels stalled at random.", tasks_woken);
    if (mismatches == 0) begin
      $display("** sorted_wakeup_timer_queue_core: PASSED **");
    end else begin
      $display("** sorted_wakeup_timer_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
